/* rtl/evm_avg_pkg.sv */
`default_nettype none

package evm_avg_pkg;

  // Q8.8 dB sample width
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Reset values of the thresholds: -15.0 dB and -20.0 dB in Q8.8
  localparam logic signed [SAMPLE_W-1:0] UPPER_RST = -16'sd3840;
  localparam logic signed [SAMPLE_W-1:0] LOWER_RST = -16'sd5120;

  typedef enum logic [1:0] {
    RATE_HALF  = 2'd0,
    RATE_3_4   = 2'd1,
    RATE_7_8   = 2'd2
  } rate_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER = 1'b0,
    REG_LOWER = 1'b1
  } cfg_reg_e;

  // transmit code info riding along the pipeline
  typedef struct packed {
    logic [1:0] code;
    logic       changed;
  } tx_info_t;

endpackage

`default_nettype wire

/* rtl/evm_avg_cell.sv */
`default_nettype none

module evm_avg_cell
  import evm_avg_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic [SAMPLE_W-1:0] d_i,
  output logic      [SAMPLE_W-1:0] q_o
);

  logic [SAMPLE_W-1:0] val_q;
  logic [SAMPLE_W-1:0] val_d;

  assign val_d = en_i ? d_i : val_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
    end else begin
      val_q <= val_d;
    end
  end

  assign q_o = val_q;

endmodule

`default_nettype wire

/* rtl/evm_avg_div.sv */
`default_nettype none

// floor(sum / WINDOW) by reciprocal multiply; one registered product stage.
// The sum is biased by 32768*WINDOW so the dividend is never negative,
// and the bias comes back out as a flip of the quotient MSB.
module evm_avg_div
  import evm_avg_pkg::*;
#(
  parameter int unsigned WINDOW = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      en_i,
  input  wire logic [SAMPLE_W+$clog2(WINDOW)-1:0]        sum_i,
  output logic      [SAMPLE_W-1:0]                       avg_o
);

  localparam int unsigned L   = $clog2(WINDOW);
  localparam int unsigned N   = SAMPLE_W + L;
  localparam int unsigned K   = N + L;
  localparam int unsigned M_W = N + 1;
  localparam int unsigned P_W = N + M_W;

  localparam logic [63:0] MULT_FULL =
    ((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [63:0] OFF_FULL  = 64'(WINDOW) << (SAMPLE_W - 1);

  localparam logic [M_W-1:0] MULT = MULT_FULL[M_W-1:0];
  localparam logic [N-1:0]   OFF  = OFF_FULL[N-1:0];

  logic [N-1:0]        biased;
  logic [P_W-1:0]      prod_d;
  logic [P_W-1:0]      prod_q;
  logic [SAMPLE_W-1:0] quot;

  assign biased = sum_i + OFF;
  assign prod_d = P_W'(biased) * P_W'(MULT);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
    end
  end

  assign quot  = prod_q[K +: SAMPLE_W];
  assign avg_o = {~quot[SAMPLE_W-1], quot[SAMPLE_W-2:0]};

endmodule

`default_nettype wire

/* rtl/evm_average_fec_rate_select.sv */
// Moving-average EVM code rate selection. Each accepted beat is one event:
// a timeout (kind 0) is taken and dropped, a frame (kind 1) pushes its EVM
// sample (0 when sample_valid is low) into a WINDOW-long chain of history
// cells, updates a running sum and yields exactly one result: the floored
// average, the receive rate request from the two threshold registers, and
// the transmit code after adopting a valid peer request. One beat is taken
// every cycle while in_stall_o is low; a frame's result is registered
// through sum update, reciprocal multiply and threshold compare, and the
// pipeline holds up to three results, stalling input only when all are full.
// Throughput is set by the running-sum loop: one cell shift and one add per
// cycle. Thresholds go through the plain write port (index 0 upper, 1 lower);
// the user must write them only while no result is pending; not enforced.
`default_nettype none

module evm_average_fec_rate_select
  import evm_avg_pkg::*;
#(
  parameter int unsigned WINDOW = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // configuration
  input  wire logic                       cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  wire logic [SAMPLE_W-1:0]        cfg_data_i,
  // event beats
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic                       kind_i,
  input  wire logic signed [SAMPLE_W-1:0] evm_sample_i,
  input  wire logic                       sample_valid_i,
  input  wire logic                       peer_valid_i,
  input  wire logic [7:0]                 peer_code_i,
  // result beats
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [1:0]                      rx_request_o,
  output logic [1:0]                      tx_code_o,
  output logic                            tx_changed_o,
  output logic signed [SAMPLE_W-1:0]      average_evm_o
);

  localparam int unsigned SUM_W = SAMPLE_W + $clog2(WINDOW);
  localparam int unsigned EXT_W = SUM_W - SAMPLE_W;

  // ---------------------------------------------------------------------
  // Threshold registers
  // ---------------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] upper_q, upper_d;
  logic signed [SAMPLE_W-1:0] lower_q, lower_d;

  always_comb begin
    upper_d = upper_q;
    lower_d = lower_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_UPPER: upper_d = cfg_data_i;
        REG_LOWER: lower_d = cfg_data_i;
        default:   ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake: a stage moves when the one after it is free
  // ---------------------------------------------------------------------
  logic s1_vld_q, s1_vld_d;
  logic s2_vld_q, s2_vld_d;
  logic out_vld_q, out_vld_d;
  logic out_ready, s2_ready, s1_ready;
  logic beat_in, frame_in;

  assign out_ready = !out_vld_q || !out_stall_i;
  assign s2_ready  = !s2_vld_q || out_ready;
  assign s1_ready  = !s1_vld_q || s2_ready;

  assign in_stall_o = !s1_ready;
  assign beat_in    = in_valid_i && s1_ready;
  assign frame_in   = beat_in && kind_i;

  assign s1_vld_d  = s1_ready  ? frame_in : s1_vld_q;
  assign s2_vld_d  = s2_ready  ? s1_vld_q : s2_vld_q;
  assign out_vld_d = out_ready ? s2_vld_q : out_vld_q;

  // ---------------------------------------------------------------------
  // History chain: cell 0 takes the new sample, the last cell is oldest
  // ---------------------------------------------------------------------
  logic [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0] tap [WINDOW];

  assign sample = sample_valid_i ? evm_sample_i : '0;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      evm_avg_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (frame_in),
        .d_i    (sample),
        .q_o    (tap[i])
      );
    end else begin : g_body
      evm_avg_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (frame_in),
        .d_i    (tap[i-1]),
        .q_o    (tap[i])
      );
    end
  end

  // Running sum, exact in SUM_W bits (wraps only in intermediate terms)
  logic [SUM_W-1:0]    sum_q, sum_d, sum_new;
  logic [SAMPLE_W-1:0] oldest;

  assign oldest  = tap[WINDOW-1];
  assign sum_new = sum_q + {{EXT_W{sample[SAMPLE_W-1]}}, sample}
                         - {{EXT_W{oldest[SAMPLE_W-1]}}, oldest};
  assign sum_d   = frame_in ? sum_new : sum_q;

  // ---------------------------------------------------------------------
  // Transmit code: adopt a valid, known and different peer request
  // ---------------------------------------------------------------------
  logic [1:0] cur_tx_q, cur_tx_d;
  logic       peer_hit;
  tx_info_t   tx_now;

  assign peer_hit = peer_valid_i && (peer_code_i <= 8'(RATE_7_8))
                    && (peer_code_i[1:0] != cur_tx_q);
  assign tx_now.code    = peer_hit ? peer_code_i[1:0] : cur_tx_q;
  assign tx_now.changed = peer_hit;
  assign cur_tx_d       = frame_in ? tx_now.code : cur_tx_q;

  // ---------------------------------------------------------------------
  // Stage 1: sum snapshot; stage 2: product; out: compare
  // ---------------------------------------------------------------------
  logic [SUM_W-1:0]    s1_sum_q;
  tx_info_t            s1_tx_q, s2_tx_q;
  logic                s2_en, out_en;
  logic [SAMPLE_W-1:0] avg;
  rate_e               rx_sel;

  assign s2_en  = s1_vld_q && s2_ready;
  assign out_en = s2_vld_q && out_ready;

  evm_avg_div #(
    .WINDOW (WINDOW)
  ) u_div (
    .clk_i  (clk_i),
    .en_i   (s2_en),
    .sum_i  (s1_sum_q),
    .avg_o  (avg)
  );

  always_comb begin
    if ($signed(avg) > upper_q) begin
      rx_sel = RATE_HALF;
    end else if ($signed(avg) > lower_q) begin
      rx_sel = RATE_3_4;
    end else begin
      rx_sel = RATE_7_8;
    end
  end

  logic [1:0]          rx_q;
  tx_info_t            out_tx_q;
  logic [SAMPLE_W-1:0] avg_q;

  // payload registers
  always_ff @(posedge clk_i) begin
    if (frame_in) begin
      s1_sum_q <= sum_new;
      s1_tx_q  <= tx_now;
    end
    if (s2_en) begin
      s2_tx_q <= s1_tx_q;
    end
    if (out_en) begin
      rx_q     <= rx_sel;
      out_tx_q <= s2_tx_q;
      avg_q    <= avg;
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q   <= UPPER_RST;
      lower_q   <= LOWER_RST;
      sum_q     <= '0;
      cur_tx_q  <= RATE_HALF;
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      upper_q   <= upper_d;
      lower_q   <= lower_d;
      sum_q     <= sum_d;
      cur_tx_q  <= cur_tx_d;
      s1_vld_q  <= s1_vld_d;
      s2_vld_q  <= s2_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign rx_request_o  = rx_q;
  assign tx_code_o     = out_tx_q.code;
  assign tx_changed_o  = out_tx_q.changed;
  assign average_evm_o = avg_q;

`ifndef SYNTHESIS
  // a timeout beat must not touch the running sum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !kind_i) |=> $stable(sum_q))
    else $error("running sum moved on a timeout beat");

  // an accepted frame always lands in stage 1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && kind_i) |=> s1_vld_q)
    else $error("frame beat lost at pipeline entry");

  // current transmit code stays one of the three rates
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_tx_q != 2'd3)
    else $error("transmit code left the valid range");

  // a reported change must match the code then in force at that frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (frame_in && peer_hit) |=> (cur_tx_q == $past(peer_code_i[1:0])))
    else $error("peer code not adopted");
`endif

endmodule

`default_nettype wire

/* verif/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import evm_avg_pkg::*;

  localparam int AVG_WIN      = 16;    // history depth of the block under test
  localparam int LAT_PAD      = 8;     // idle cycles after the last result
  localparam int HOLD_LEN     = 300;   // long receiver hold-off, in cycles
  localparam int STUCK_LIMIT  = 5000;  // cycles without any beat before giving up
  localparam int MAX_REPORTS  = 10;

  // one input beat as the sender sees it
  typedef struct {
    logic                       is_frame;
    logic signed [SAMPLE_W-1:0] evm;
    logic                       evm_ok;
    logic                       peer_ok;
    logic [7:0]                 peer_code;
  } event_beat_t;

  // one result beat
  typedef struct {
    rate_e                      rx;
    rate_e                      tx;
    logic                       changed;
    logic signed [SAMPLE_W-1:0] average;
  } rate_result_t;

  // ---------------------------------------------------------------------------
  // DUT ports, all known from time zero
  // ---------------------------------------------------------------------------
  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       cfg_we_i       = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_idx_i      = REG_UPPER;
  logic [SAMPLE_W-1:0]        cfg_data_i     = '0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_stall_o;
  logic                       kind_i         = 1'b0;
  logic signed [SAMPLE_W-1:0] evm_sample_i   = '0;
  logic                       sample_valid_i = 1'b0;
  logic                       peer_valid_i   = 1'b0;
  logic [7:0]                 peer_code_i    = '0;
  logic                       out_valid_o;
  logic                       out_stall_i    = 1'b0;
  logic [1:0]                 rx_request_o;
  logic [1:0]                 tx_code_o;
  logic                       tx_changed_o;
  logic signed [SAMPLE_W-1:0] average_evm_o;

  evm_average_fec_rate_select #(
    .WINDOW(AVG_WIN)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .evm_sample_i  (evm_sample_i),
    .sample_valid_i(sample_valid_i),
    .peer_valid_i  (peer_valid_i),
    .peer_code_i   (peer_code_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .rx_request_o  (rx_request_o),
    .tx_code_o     (tx_code_o),
    .tx_changed_o  (tx_changed_o),
    .average_evm_o (average_evm_o)
  );

  // ---------------------------------------------------------------------------
  // Testbench state
  // ---------------------------------------------------------------------------
  event_beat_t  pending_events_q[$];    // beats not yet offered
  rate_result_t expected_results_q[$];  // results predicted, not yet seen
  event_beat_t  drv_beat;

  int tx_gap_pct   = 0;   // sender idles this often (percent)
  int rx_stall_pct = 0;   // receiver stalls this often (percent)
  logic hold_req   = 1'b0;
  int hold_cnt     = 0;
  logic in_taken   = 1'b0;
  int mismatch_cnt = 0;
  int stuck_cnt    = 0;

  // predictor copy of the block's state and thresholds
  logic signed [SAMPLE_W-1:0] hist_mem[AVG_WIN];
  int                         wr_slot;
  int                         win_sum;
  rate_e                      cur_tx;
  logic signed [SAMPLE_W-1:0] upper_thr;
  logic signed [SAMPLE_W-1:0] lower_thr;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: applies one accepted beat, queues the result a frame causes.
  // Timeouts leave the state alone and produce nothing.
  // ---------------------------------------------------------------------------
  task automatic take_event();
    logic signed [SAMPLE_W-1:0] s;
    int q;
    rate_result_t r;
    if (kind_i) begin
      // a bad frame still advances the window, with a zero sample
      s = sample_valid_i ? evm_sample_i : '0;
      win_sum = win_sum + int'(s) - int'(hist_mem[wr_slot]);
      hist_mem[wr_slot] = s;
      wr_slot = (wr_slot + 1) % AVG_WIN;
      // floor division, toward minus infinity
      q = win_sum / AVG_WIN;
      if ((win_sum % AVG_WIN) != 0 && win_sum < 0) q--;
      r.average = q[SAMPLE_W-1:0];
      // strict compares, upper first, thresholds may be out of order
      if (q > int'(upper_thr)) r.rx = RATE_HALF;
      else if (q > int'(lower_thr)) r.rx = RATE_3_4;
      else r.rx = RATE_7_8;
      // peer request adopted only if valid, a known code, and different
      r.changed = 1'b0;
      if (peer_valid_i && peer_code_i <= 8'(RATE_7_8) && peer_code_i[1:0] != cur_tx) begin
        cur_tx = rate_e'(peer_code_i[1:0]);
        r.changed = 1'b1;
      end
      r.tx = cur_tx;
      expected_results_q.push_back(r);
    end
  endtask

  task automatic check_result();
    rate_result_t e;
    if (expected_results_q.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_REPORTS)
        $display("%0t: result beat with nothing expected: rx %0d tx %0d chg %0d avg %0d",
                 $realtime, rx_request_o, tx_code_o, tx_changed_o, average_evm_o);
    end else begin
      e = expected_results_q.pop_front();
      if (rx_request_o !== e.rx || tx_code_o !== e.tx || tx_changed_o !== e.changed ||
          average_evm_o !== e.average) begin
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_REPORTS)
          $display({"%0t: mismatch exp rx %0d tx %0d chg %0d avg %0d",
                    " / got rx %0d tx %0d chg %0d avg %0d"},
                   $realtime, e.rx, e.tx, e.changed, e.average,
                   rx_request_o, tx_code_o, tx_changed_o, average_evm_o);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge. The input side is
  // predicted first so that a result in the same cycle still finds its
  // expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    in_taken = rst_ni && in_valid_i && !in_stall_o;
    if (in_taken) take_event();
    if (rst_ni && out_valid_o && !out_stall_i) check_result();
  end

  // Driver: new beat at the falling edge once the current one is taken;
  // a stalled beat is held unchanged.
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (pending_events_q.size() != 0 && $urandom_range(99) >= tx_gap_pct) begin
        drv_beat = pending_events_q.pop_front();
        kind_i         <= drv_beat.is_frame;
        evm_sample_i   <= drv_beat.evm;
        sample_valid_i <= drv_beat.evm_ok;
        peer_valid_i   <= drv_beat.peer_ok;
        peer_code_i    <= drv_beat.peer_code;
        in_valid_i     <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested so the
  // pipe fills and the input backs up.
  always @(negedge clk_i) begin
    if (hold_req && hold_cnt < HOLD_LEN) begin
      hold_cnt    <= hold_cnt + 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  // Watchdog: any beat or register write restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i || !rst_ni)
      stuck_cnt <= 0;
    else
      stuck_cnt <= stuck_cnt + 1;
    if (stuck_cnt >= STUCK_LIMIT) begin
      $display("** evm_average_fec_rate_select: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_event(logic fr, logic signed [SAMPLE_W-1:0] evm, logic ok,
                                     logic pok, logic [7:0] pc);
    event_beat_t b;
    b.is_frame  = fr;
    b.evm       = evm;
    b.evm_ok    = ok;
    b.peer_ok   = pok;
    b.peer_code = pc;
    pending_events_q.push_back(b);
  endfunction

  function automatic event_beat_t rand_event();
    event_beat_t b;
    int sel;
    b.is_frame = ($urandom_range(99) >= 12);
    sel = $urandom_range(99);
    if (sel < 10) b.evm = SAMPLE_W'($urandom_range(16'hFFFF));
    else if (sel < 15) b.evm = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
    else b.evm = SAMPLE_W'(int'($urandom_range(9000)) - 8000);   // typical dB range
    b.evm_ok    = ($urandom_range(99) < 88);
    b.peer_ok   = ($urandom_range(99) < 60);
    b.peer_code = ($urandom_range(99) < 80) ? 8'($urandom_range(2)) : 8'($urandom_range(255));
    return b;
  endfunction

  // Mostly single random beats; now and then a run long enough to fill the
  // window with one value, so the average lands on extremes and thresholds.
  task automatic push_random(int n);
    int cnt;
    int len;
    logic signed [SAMPLE_W-1:0] v;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(99) < 3) begin
        case ($urandom_range(4))
          0: v = 16'sh8000;
          1: v = 16'sh7FFF;
          2: v = upper_thr;
          3: v = lower_thr;
          default: v = upper_thr + 16'sd1;
        endcase
        len = $urandom_range(20, AVG_WIN);
        repeat (len) push_event(1'b1, v, 1'b1, 1'($urandom_range(1)), 8'($urandom_range(3)));
        cnt += len;
      end else begin
        pending_events_q.push_back(rand_event());
        cnt++;
      end
    end
  endtask

  // Idle means: nothing queued or on the bus and nothing outstanding,
  // followed by a LAT_PAD wait.
  task automatic wait_idle();
    while (pending_events_q.size() != 0 || in_valid_i || expected_results_q.size() != 0)
      @(posedge clk_i);
    repeat (LAT_PAD) @(posedge clk_i);
  endtask

  task automatic write_threshold(cfg_reg_e idx, logic signed [SAMPLE_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    if (idx == REG_UPPER) upper_thr = val;
    else lower_thr = val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(logic signed [SAMPLE_W-1:0] up, logic signed [SAMPLE_W-1:0] lo,
                           int n, int gap, int stall, logic hold);
    wait_idle();
    write_threshold(REG_UPPER, up);
    write_threshold(REG_LOWER, lo);
    @(posedge clk_i);
    tx_gap_pct   = gap;
    rx_stall_pct = stall;
    push_random(n);
    if (hold) hold_req = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int u;
    int l;
    foreach (hist_mem[i]) hist_mem[i] = '0;
    wr_slot   = 0;
    win_sum   = 0;
    cur_tx    = RATE_HALF;
    upper_thr = UPPER_RST;
    lower_thr = LOWER_RST;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, reset thresholds, sender 24% / receiver 84% idle
    tx_gap_pct   = 24;
    rx_stall_pct = 84;
    push_event(1'b0, 16'sh7FFF, 1'b1, 1'b1, 8'd1);    // timeout: no result, no change
    push_event(1'b1, -16'sd1,   1'b1, 1'b0, 8'd0);    // negative sum rounds down
    push_event(1'b1, 16'sd15,   1'b1, 1'b0, 8'd0);
    push_event(1'b1, 16'sh7FFF, 1'b1, 1'b1, 8'd1);    // peer asks 3/4
    push_event(1'b1, 16'sh8000, 1'b1, 1'b1, 8'd1);    // same code again: no change
    push_event(1'b1, 16'sh8000, 1'b0, 1'b1, 8'd2);    // bad frame counts as 0 dB
    push_event(1'b1, 16'sh8000, 1'b1, 1'b0, 8'd2);    // peer info not valid
    push_event(1'b1, 16'sh8000, 1'b1, 1'b1, 8'd3);    // unknown codes ignored
    push_event(1'b1, 16'sh8000, 1'b1, 1'b1, 8'd255);
    push_event(1'b1, 16'sh8000, 1'b1, 1'b1, 8'd170);
    push_event(1'b1, 16'sh8000, 1'b1, 1'b1, 8'd85);
    push_event(1'b1, 16'sh8000, 1'b1, 1'b1, 8'd2);    // to 7/8
    push_event(1'b1, 16'sh8000, 1'b1, 1'b1, 8'd0);    // back to 1/2
    push_event(1'b0, 16'sh8000, 1'b0, 1'b1, 8'd2);    // timeout carrying a request
    push_event(1'b1, -16'sd3840, 1'b1, 1'b1, 8'd1);
    push_event(1'b1, -16'sd5120, 1'b1, 1'b0, 8'd2);
    push_event(1'b1, 16'sh5555, 1'b1, 1'b1, 8'd2);
    push_event(1'b1, 16'shAAAA, 1'b1, 1'b1, 8'd0);
    push_event(1'b1, 16'sh7FFF, 1'b0, 1'b0, 8'd255);
    push_event(1'b1, 16'sh0000, 1'b1, 1'b1, 8'd1);

    // random part over several threshold settings and idling modes;
    // the first phase carries the long receiver hold-off
    run_phase(-16'sd3000, -16'sd6000, 350, 24, 84, 1'b1);
    run_phase(16'sh7FFF, 16'sh8000, 150, 24, 84, 1'b0);   // widest gap
    run_phase(16'sh8000, 16'sh7FFF, 150, 84, 24, 1'b0);   // reversed order
    u = int'($urandom_range(4000)) - 6000;
    run_phase(SAMPLE_W'(u), SAMPLE_W'(u), 250, 84, 24, 1'b0);   // equal thresholds
    run_phase(SAMPLE_W'($urandom_range(16'hFFFF)), SAMPLE_W'($urandom_range(16'hFFFF)),
              150, 84, 24, 1'b0);
    l = int'($urandom_range(4000)) - 8000;
    u = l + int'($urandom_range(4000));
    run_phase(SAMPLE_W'(u), SAMPLE_W'(l), 400, 0, 0, 1'b0);
    run_phase(16'sd0, -16'sd1, 250, 0, 0, 1'b0);
    wait_idle();

    if (mismatch_cnt == 0 && expected_results_q.size() == 0) begin
      $display("** evm_average_fec_rate_select: PASSED **");
    end else begin
      $display("** evm_average_fec_rate_select: FAILED **");
    end
    $finish;
  end

endmodule
